// ===== hdl/pars_pkg.sv =====
// ----------------------------------------------------------------------------
// pars_pkg
// Shared types and constants for the permutation advance / range-sum unit.
// ----------------------------------------------------------------------------
package pars_pkg;

  localparam int unsigned LEN_W   = 20;
  localparam int unsigned AMT_W   = 37;
  localparam int unsigned TOT_W   = 39;
  localparam int unsigned RANK_W  = 64;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // factorials 0! .. 20!
  function automatic logic [RANK_W-1:0] fact(input logic [4:0] k);
    logic [RANK_W-1:0] f;
    f = 64'd1;
    case (k)
      5'd0:  f = 64'd1;
      5'd1:  f = 64'd1;
      5'd2:  f = 64'd2;
      5'd3:  f = 64'd6;
      5'd4:  f = 64'd24;
      5'd5:  f = 64'd120;
      5'd6:  f = 64'd720;
      5'd7:  f = 64'd5040;
      5'd8:  f = 64'd40320;
      5'd9:  f = 64'd362880;
      5'd10: f = 64'd3628800;
      5'd11: f = 64'd39916800;
      5'd12: f = 64'd479001600;
      5'd13: f = 64'd6227020800;
      5'd14: f = 64'd87178291200;
      5'd15: f = 64'd1307674368000;
      5'd16: f = 64'd20922789888000;
      5'd17: f = 64'd355687428096000;
      5'd18: f = 64'd6402373705728000;
      5'd19: f = 64'd121645100408832000;
      5'd20: f = 64'd2432902008176640000;
      default: f = 64'd1;
    endcase
    return f;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAT,
    ST_DIGIT,
    ST_DIV,
    ST_SCAN,
    ST_Q_HI,
    ST_Q_LO,
    ST_Q_SUB
  } state_t;

  // request from sequencer to the shared add/subtract unit
  typedef struct packed {
    logic [RANK_W-1:0] a;
    logic [RANK_W-1:0] b;
    logic              sub;
  } alu_req_t;

endpackage

// ===== hdl/pars_alu.sv =====
// ----------------------------------------------------------------------------
// pars_alu
// Shared wide add / subtract unit with borrow flag, used for the saturate, divide and query-subtract steps.
// ----------------------------------------------------------------------------
module pars_alu
  import pars_pkg::*;
(
  input  alu_req_t          req,
  output logic [RANK_W-1:0] res,
  output logic              borrow
);

  logic [RANK_W:0] sum;

  // one adder, b inverted for subtract
  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} + {1'b0, ~req.b} + {{RANK_W{1'b0}}, 1'b1};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    res    = sum[RANK_W-1:0];
    borrow = req.sub ? ~sum[RANK_W] : sum[RANK_W];
  end

endmodule

// ===== hdl/permutation_advance_range_sum_unit.sv =====
// ----------------------------------------------------------------------------
// permutation_advance_range_sum_unit
// Keeps a permutation rank, unranks the tail by repeated subtraction and
// answers range-sum queries from closed-form head sums and tail prefix sums.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | operation, amount, left_end, right_end
//  out     | output    | out_valid/stall  | range_total, status
//  cfg     | input     | cfg_valid/ready  | cfg_data (total_length)
//
// After an advance beat the sequencer is busy with a saturate step, per
// digit a setup step, a subtraction per digit unit plus the borrow step, a
// scan step per position up to the pick, and a final exit. A query passes
// through the high-sum, low-sum and subtract states, the last one held while
// an earlier result still waits in the output register. Reset is synchronous
// and returns rank zero, identity tail and length 1. The input is stalled
// while an item is in work.
module permutation_advance_range_sum_unit
  import pars_pkg::*;
#(
  parameter int unsigned TAIL_MAX = 14
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [AMT_W-1:0]   amount,
  input  logic [LEN_W-1:0]   left_end,
  input  logic [LEN_W-1:0]   right_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOT_W-1:0]   range_total,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data
);

  localparam int unsigned IW = (TAIL_MAX > 1) ? $clog2(TAIL_MAX) : 1;
  localparam int unsigned VW = IW;
  localparam int unsigned SW = $clog2(TAIL_MAX * TAIL_MAX + 1);
  localparam int unsigned CW = $clog2(TAIL_MAX + 1);

  state_t state, state_next;

  logic [LEN_W-1:0]  total_length;
  logic [RANK_W-1:0] current_rank;
  logic [RANK_W-1:0] rem;
  logic [VW-1:0]     tail_values [TAIL_MAX];
  logic [SW-1:0]     tail_prefix_sums [TAIL_MAX];
  logic [TAIL_MAX-1:0] used;
  logic [CW-1:0]     dig_i;
  logic [CW-1:0]     digit;
  logic [CW-1:0]     pos;
  logic [SW-1:0]     acc;
  logic [AMT_W-1:0]  amt_r;
  logic [LEN_W-1:0]  l_r, r_r;
  logic [RANK_W-1:0] hi_sum;
  logic [RANK_W-1:0] lo_sum;
  logic              bad;
  logic              out_full;
  logic              out_load;

  logic [CW-1:0]     tlen;
  logic [RANK_W-1:0] limit;
  logic [RANK_W-1:0] cur_f;
  logic [LEN_W-1:0]  head;

  alu_req_t          req;
  logic [RANK_W-1:0] alu_res;
  logic              alu_borrow;

  pars_alu u_alu (.req(req), .res(alu_res), .borrow(alu_borrow));

  assign tlen  = (total_length < LEN_W'(TAIL_MAX)) ? CW'(total_length) : CW'(TAIL_MAX);
  assign limit = fact(5'(tlen)) - 64'd1;
  assign cur_f = fact(5'(tlen - dig_i - CW'(1)));
  assign head  = total_length - LEN_W'(tlen);

  // prefix total of first k positions (closed form head + stored tail)
  function automatic logic [RANK_W-1:0] ptot(input logic [LEN_W-1:0] k,
                                             input logic [LEN_W-1:0] hd,
                                             input logic [SW-1:0] ps);
    logic [LEN_W:0]     kk, hh;
    logic [2*LEN_W+1:0] ksq, hsq, tl;
    kk  = {1'b0, k};
    hh  = {1'b0, hd};
    ksq = kk * (kk + (LEN_W+1)'(1));
    hsq = hh * (hh + (LEN_W+1)'(1));
    tl  = (kk - hh) * (hh + (LEN_W+1)'(1));
    if (kk <= hh) return RANK_W'(ksq >> 1);
    return RANK_W'(hsq >> 1) + RANK_W'(ps) + RANK_W'(tl);
  endfunction

  logic [LEN_W-1:0]  qk;
  logic [LEN_W-1:0]  qidx_w;
  logic [IW-1:0]     qidx;
  logic [RANK_W-1:0] pt;
  assign qk     = (state == ST_Q_HI) ? r_r : (l_r - LEN_W'(1));
  assign qidx_w = (qk > head) ? (qk - head - LEN_W'(1)) : '0;
  assign qidx   = (qidx_w >= LEN_W'(TAIL_MAX)) ? IW'(TAIL_MAX - 1) : IW'(qidx_w);
  assign pt     = ptot(qk, head, tail_prefix_sums[qidx]);

  // result register takes a new beat when empty or being drained
  assign out_load = (state == ST_Q_SUB) && (!out_full || !out_stall);

  // shared unit operand select
  always_comb begin
    req = '{a: '0, b: '0, sub: 1'b1};
    case (state)
      ST_SAT:   req = '{a: limit, b: current_rank, sub: 1'b1};
      ST_DIV:   req = '{a: rem, b: cur_f, sub: 1'b1};
      ST_Q_SUB: req = '{a: hi_sum, b: lo_sum, sub: 1'b1};
      default:  req = '{a: '0, b: '0, sub: 1'b1};
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && !in_stall) begin
        state_next = (operation == OP_QUERY) ? ST_Q_HI : ST_SAT;
      end
      ST_SAT:   state_next = ST_DIGIT;
      ST_DIGIT: state_next = (dig_i >= tlen) ? ST_IDLE : ST_DIV;
      ST_DIV:   if (alu_borrow) state_next = ST_SCAN;
      ST_SCAN:  if (!used[pos[IW-1:0]] && digit == '0) state_next = ST_DIGIT;
      ST_Q_HI:  state_next = ST_Q_LO;
      ST_Q_LO:  state_next = ST_Q_SUB;
      ST_Q_SUB: if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE) && !out_full;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      total_length <= rst ? LEN_W'(1) : cfg_data;
      current_rank <= '0;
      for (int i = 0; i < TAIL_MAX; i++) begin
        tail_values[i]      <= VW'(i);
        tail_prefix_sums[i] <= SW'((i * (i + 1)) / 2);
      end
    end else begin
      case (state)
        ST_IDLE: begin
          amt_r <= amount;
          l_r   <= left_end;
          r_r   <= right_end;
        end
        ST_SAT: begin
          // limit - rank < amount -> saturate
          if (alu_borrow || alu_res < RANK_W'(amt_r)) begin
            current_rank <= limit;
            rem          <= limit;
          end else begin
            current_rank <= current_rank + RANK_W'(amt_r);
            rem          <= current_rank + RANK_W'(amt_r);
          end
          dig_i <= '0;
          used  <= '0;
          acc   <= '0;
          digit <= '0;
        end
        ST_DIV: begin
          if (!alu_borrow) begin
            rem   <= alu_res;
            digit <= digit + CW'(1);
          end else begin
            pos <= '0;
          end
        end
        ST_SCAN: begin
          if (!used[pos[IW-1:0]]) begin
            if (digit == '0) begin
              used[pos[IW-1:0]]          <= 1'b1;
              tail_values[dig_i[IW-1:0]] <= pos[VW-1:0];
              tail_prefix_sums[dig_i[IW-1:0]] <= acc + SW'(pos);
              acc   <= acc + SW'(pos);
              dig_i <= dig_i + CW'(1);
            end else begin
              digit <= digit - CW'(1);
            end
          end
          pos <= pos + CW'(1);
        end
        ST_Q_HI: begin
          bad    <= (l_r < LEN_W'(1)) || (r_r > total_length) || (l_r > r_r);
          hi_sum <= pt;
        end
        ST_Q_LO: begin
          lo_sum <= pt;
        end
        ST_Q_SUB: begin
          if (out_load) begin
            range_total <= bad ? '0 : alu_res[TOT_W-1:0];
            status      <= bad;
          end
        end
        default: ;
      endcase
    end
  end

  // digit loop never scans past position TAIL_MAX - 1
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> pos < CW'(TAIL_MAX)) else $error("scan overrun");
  // result only after query path
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_Q_SUB) else $error("spurious result");
  // rank never exceeds the tail limit in the digit step
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIGIT |-> current_rank <= limit) else $error("rank over limit");
  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range_total) && $stable(status))
    else $error("result changed under stall");

endmodule
